// File: design/ufim_pkg.sv
// Package for the union-find island merge block.
// Holds the item and result types, opcodes, controller states and the
// command/status structs between controller and datapath. Depends on nothing.
package ufim_pkg;

    localparam int ID_W  = 10;
    localparam int CNT_W = 11;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_MERGE   = 2'd1,
        OP_QUERY   = 2'd2,
        OP_INVALID = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  first_element;
        logic [ID_W-1:0]  second_element;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0]  island_id;
        logic             already_joined;
        logic             error;
    } t_result;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RD_A,
        ST_CHK_A,
        ST_RD_B,
        ST_CHK_B
    } t_state;

    typedef enum logic [1:0] {
        NODE_HOLD,
        NODE_FIRST,
        NODE_SECOND,
        NODE_UP
    } t_node_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SWEEP,
        WR_LINK
    } t_wr_sel;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_ERROR,
        RES_ROOT,
        RES_MERGE
    } t_res_kind;

    typedef struct packed {
        t_node_sel node_sel;
        logic      rd_en;
        logic      rd_up;
        t_wr_sel   wr_sel;
        logic      idx_clr;
        logic      idx_inc;
        logic      root_a_ld;
        logic      res_ld;
        t_res_kind res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic first_oob;
        logic second_oob;
        logic count_zero;
        logic sweep_last_init;
        logic sweep_last_clear;
        logic root_found;
        logic roots_equal;
    } t_dp_stat;

endpackage

// File: design/ufim_ctrl.sv
// Controller for the union-find island merge block.
// Sequences table sweeps and parent-link walks; drives the datapath
// through ufim_pkg::t_dp_cmd and reads back ufim_pkg::t_dp_stat.
module ufim_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ufim_pkg::t_op      i_op,
    input  ufim_pkg::t_dp_stat i_stat,
    output ufim_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    ufim_pkg::t_state r_state, n_state;
    ufim_pkg::t_op    r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ufim_pkg::ST_INIT;
            r_op    <= ufim_pkg::OP_CLEAR;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        case (r_state)
            ufim_pkg::ST_INIT: begin
                o_cmd.wr_sel  = ufim_pkg::WR_SWEEP;
                o_cmd.idx_inc = 1'b1;
                if (i_stat.sweep_last_init) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ufim_pkg::ST_IDLE;
                end
            end
            ufim_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_op = i_op;
                    case (i_op)
                        ufim_pkg::OP_CLEAR: begin
                            if (i_stat.count_zero) begin
                                o_cmd.res_ld   = 1'b1;
                                o_cmd.res_kind = ufim_pkg::RES_ZERO;
                            end else begin
                                n_state = ufim_pkg::ST_CLEAR;
                            end
                        end
                        ufim_pkg::OP_MERGE: begin
                            if (i_stat.first_oob || i_stat.second_oob) begin
                                o_cmd.res_ld   = 1'b1;
                                o_cmd.res_kind = ufim_pkg::RES_ERROR;
                            end else begin
                                o_cmd.node_sel = ufim_pkg::NODE_FIRST;
                                n_state        = ufim_pkg::ST_RD_A;
                            end
                        end
                        ufim_pkg::OP_QUERY: begin
                            if (i_stat.first_oob) begin
                                o_cmd.res_ld   = 1'b1;
                                o_cmd.res_kind = ufim_pkg::RES_ERROR;
                            end else begin
                                o_cmd.node_sel = ufim_pkg::NODE_FIRST;
                                n_state        = ufim_pkg::ST_RD_A;
                            end
                        end
                        default: begin
                            o_cmd.res_ld   = 1'b1;
                            o_cmd.res_kind = ufim_pkg::RES_ERROR;
                        end
                    endcase
                end
            end
            ufim_pkg::ST_CLEAR: begin
                o_cmd.wr_sel  = ufim_pkg::WR_SWEEP;
                o_cmd.idx_inc = 1'b1;
                if (i_stat.sweep_last_clear) begin
                    o_cmd.idx_clr  = 1'b1;
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_kind = ufim_pkg::RES_ZERO;
                    n_state        = ufim_pkg::ST_IDLE;
                end
            end
            ufim_pkg::ST_RD_A: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ufim_pkg::ST_CHK_A;
            end
            ufim_pkg::ST_CHK_A: begin
                if (i_stat.root_found) begin
                    if (r_op == ufim_pkg::OP_MERGE) begin
                        o_cmd.root_a_ld = 1'b1;
                        o_cmd.node_sel  = ufim_pkg::NODE_SECOND;
                        n_state         = ufim_pkg::ST_RD_B;
                    end else begin
                        o_cmd.res_ld   = 1'b1;
                        o_cmd.res_kind = ufim_pkg::RES_ROOT;
                        n_state        = ufim_pkg::ST_IDLE;
                    end
                end else begin
                    // step up one link and read the parent straight away
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_up    = 1'b1;
                    o_cmd.node_sel = ufim_pkg::NODE_UP;
                end
            end
            ufim_pkg::ST_RD_B: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ufim_pkg::ST_CHK_B;
            end
            ufim_pkg::ST_CHK_B: begin
                if (i_stat.root_found) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_kind = ufim_pkg::RES_MERGE;
                    if (!i_stat.roots_equal) begin
                        o_cmd.wr_sel = ufim_pkg::WR_LINK;
                    end
                    n_state = ufim_pkg::ST_IDLE;
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_up    = 1'b1;
                    o_cmd.node_sel = ufim_pkg::NODE_UP;
                end
            end
            default: begin
                n_state = ufim_pkg::ST_INIT;
            end
        endcase
    end

    assign o_busy = (r_state != ufim_pkg::ST_IDLE);

endmodule

// File: design/ufim_dp.sv
// Datapath for the union-find island merge block: parent table memory,
// walk registers, sweep counter, element count and result register.
// Driven by ufim_ctrl through the structs in ufim_pkg.
module ufim_dp #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ufim_pkg::CNT_W-1:0]    i_cfg_data,
    input  ufim_pkg::t_item               i_item,
    input  ufim_pkg::t_dp_cmd             i_cmd,
    output ufim_pkg::t_dp_stat            o_stat,
    output ufim_pkg::t_result             o_result,
    output logic                          o_result_valid
);

    // indices are ID_W bits wide, so no more entries than that can reach
    localparam int DEPTH = (MAX_ELEMENTS < (1 << ufim_pkg::ID_W)) ?
                           MAX_ELEMENTS : (1 << ufim_pkg::ID_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = $clog2(MAX_ELEMENTS + 1);
    localparam int NW    = (MW > ufim_pkg::CNT_W) ? MW : ufim_pkg::CNT_W;

    localparam logic [NW-1:0] MAX_N    = NW'(MAX_ELEMENTS);
    localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);

    logic [ufim_pkg::ID_W-1:0]  r_mem [DEPTH];
    logic [ufim_pkg::ID_W-1:0]  r_rdata;
    logic [ufim_pkg::ID_W-1:0]  r_node;
    logic [ufim_pkg::ID_W-1:0]  r_second;
    logic [ufim_pkg::ID_W-1:0]  r_root_a;
    logic [AW-1:0]              r_idx;
    logic [ufim_pkg::CNT_W-1:0] r_count;
    ufim_pkg::t_result          r_result;
    logic                       r_result_valid;

    logic [NW-1:0]              cfg_n;
    logic [NW-1:0]              live_n;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic [ufim_pkg::ID_W-1:0]  wr_data;
    logic                       wr_en;
    ufim_pkg::t_result          res_next;

    assign cfg_n  = NW'(r_count);
    assign live_n = (cfg_n > MAX_N) ? MAX_N : cfg_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    // parent table: one write and one registered read per cycle
    assign rd_addr = i_cmd.rd_up ? r_rdata[AW-1:0] : r_node[AW-1:0];
    assign wr_en   = (i_cmd.wr_sel != ufim_pkg::WR_NONE);
    assign wr_addr = (i_cmd.wr_sel == ufim_pkg::WR_LINK) ? r_root_a[AW-1:0] : r_idx;
    assign wr_data = (i_cmd.wr_sel == ufim_pkg::WR_LINK) ? r_node : ufim_pkg::ID_W'(r_idx);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.node_sel)
            ufim_pkg::NODE_FIRST: begin
                r_node   <= i_item.first_element;
                r_second <= i_item.second_element;
            end
            ufim_pkg::NODE_SECOND: r_node <= r_second;
            ufim_pkg::NODE_UP:     r_node <= r_rdata;
            default:               r_node <= r_node;
        endcase
        if (i_cmd.root_a_ld) begin
            r_root_a <= r_node;
        end
    end

    always_comb begin
        o_stat.first_oob        = (NW'(i_item.first_element) >= live_n);
        o_stat.second_oob       = (NW'(i_item.second_element) >= live_n);
        o_stat.count_zero       = (live_n == '0);
        o_stat.sweep_last_init  = (r_idx == IDX_LAST);
        o_stat.sweep_last_clear = ((NW'(r_idx) + NW'(1)) >= live_n) || (r_idx == IDX_LAST);
        o_stat.root_found       = (r_rdata == r_node) || (NW'(r_rdata) >= MAX_N);
        o_stat.roots_equal      = (r_root_a == r_node);
    end

    always_comb begin
        res_next = '0;
        case (i_cmd.res_kind)
            ufim_pkg::RES_ERROR: res_next.error = 1'b1;
            ufim_pkg::RES_ROOT:  res_next.island_id = r_node;
            ufim_pkg::RES_MERGE: begin
                res_next.island_id      = r_node;
                res_next.already_joined = o_stat.roots_equal;
            end
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            r_result <= res_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd.res_ld;
        end
    end

    assign o_result       = r_result;
    assign o_result_valid = r_result_valid;

endmodule

// File: design/union_find_island_merge.sv
// Union-find island merge: disjoint-set forest with no path compression.
// After reset the block walks the whole parent table, writing each entry's
// own index, and holds busy high meanwhile. An item is taken when start is
// high and busy low. Error items and a clear with zero elements in use give
// their result in the next cycle with no busy time. A clear sweeps the table
// entries in use, one table entry a cycle. A query walks the parent links
// from the element to its root, a merge walks them from both elements in
// turn; each link is one read on the single table read port. The result
// strobe o_result_valid is high for one cycle and cannot be held off; busy
// is already low in that cycle, so the next item may be started alongside
// it. The user must write the element count through i_cfg_we/i_cfg_data
// only while the block is idle; the block itself does not enforce this.
// Depends on ufim_pkg, ufim_ctrl and ufim_dp.
module union_find_island_merge #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ufim_pkg::t_item            i_item,
    output ufim_pkg::t_result          o_result,
    output logic                       o_result_valid,
    input  logic                       i_cfg_we,
    input  logic [ufim_pkg::CNT_W-1:0] i_cfg_data
);

    ufim_pkg::t_dp_cmd  dp_cmd;
    ufim_pkg::t_dp_stat dp_stat;
    logic               ctrl_busy;

    // hold off items while reset is applied
    assign busy = ctrl_busy || !i_rst_n;

    ufim_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_item.op),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (ctrl_busy)
    );

    ufim_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_item         (i_item),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

`ifndef SYNTHESIS
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted item neither busy nor answered");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.error) |->
            (o_result.island_id == '0 && !o_result.already_joined))
        else $error("error result carries island or joined flag");

    a_bad_op_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.op == ufim_pkg::OP_INVALID) |=>
            (o_result_valid && o_result.error))
        else $error("invalid op not flagged");
`endif

endmodule
